// ===== sv/i2cs_pkg.sv =====
// Package for the I2C address scanner: phase codes, widths, result struct
// and the gap counter load helper. No dependencies.
`timescale 1ns / 1ps
package i2cs_pkg;

	// Gap counter width and the other field widths
	localparam int GAP_COUNTER_BITS = 16;
	localparam int GAP_TICKS_W      = 16;
	localparam int ADDR_W           = 7;
	localparam int COUNT_W          = 8;
	localparam int PHASE_W          = 4;

	// APB register map: one 32-bit register per word
	localparam int PADDR_W  = 4;
	localparam int REG_SEL_W = 2;
	localparam logic [REG_SEL_W-1:0] REG_FIRST_ADDR = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_LAST_ADDR  = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_GAP_TICKS  = 2'd2;

	// Reset values of the configuration registers
	localparam logic [ADDR_W-1:0]      FIRST_ADDR_RST = 7'h03;
	localparam logic [ADDR_W-1:0]      LAST_ADDR_RST  = 7'h77;
	localparam logic [GAP_TICKS_W-1:0] GAP_TICKS_RST  = 16'd100;

	// Bus phase codes of the sequencer
	localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_S_SCLH = 4'd1;
	localparam logic [PHASE_W-1:0] PH_S_SDAL = 4'd2;
	localparam logic [PHASE_W-1:0] PH_S_SCLL = 4'd3;
	localparam logic [PHASE_W-1:0] PH_B_SET  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_B_SCLH = 4'd5;
	localparam logic [PHASE_W-1:0] PH_B_SCLL = 4'd6;
	localparam logic [PHASE_W-1:0] PH_A_REL  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_A_SCLH = 4'd8;
	localparam logic [PHASE_W-1:0] PH_A_SCLL = 4'd9;
	localparam logic [PHASE_W-1:0] PH_A_TAKE = 4'd10;
	localparam logic [PHASE_W-1:0] PH_P_SDAL = 4'd11;
	localparam logic [PHASE_W-1:0] PH_P_SCLH = 4'd12;
	localparam logic [PHASE_W-1:0] PH_P_SDAH = 4'd13;
	localparam logic [PHASE_W-1:0] PH_GAP    = 4'd14;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [ADDR_W-1:0]      first_address;
		logic [ADDR_W-1:0]      last_address;
		logic [GAP_TICKS_W-1:0] gap_ticks;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic               scl_out;
		logic               sda_out;
		logic               sda_released;
		logic               ack_valid;
		logic [ADDR_W-1:0]  ack_address;
		logic               busy_res;
		logic               scan_done;
		logic [COUNT_W-1:0] found_count;
	} res_t;

	// Gap load value, saturated to the counter range
	function automatic logic [GAP_COUNTER_BITS-1:0] gap_load(
			input logic [GAP_TICKS_W-1:0] ticks);
		logic [63:0] maxc;
		logic [63:0] g;
		maxc = (64'd1 << GAP_COUNTER_BITS) - 64'd1;
		g    = 64'(ticks);
		if (g > maxc) begin
			g = maxc;
		end
		return GAP_COUNTER_BITS'(g);
	endfunction

endpackage

// ===== sv/i2cs_apb.sv =====
// APB configuration registers of the I2C address scanner.
// Depends on i2cs_pkg for the register map and reset values.
`timescale 1ns / 1ps
module i2cs_apb
	import i2cs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [ADDR_W-1:0]      first_q;
	logic [ADDR_W-1:0]      last_q;
	logic [GAP_TICKS_W-1:0] gap_q;
	logic [REG_SEL_W-1:0]   sel;
	logic                   wr_en;

	assign pready = 1'b1;
	assign sel    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;

	// Register writes; unmapped words are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_ADDR_RST;
			last_q  <= LAST_ADDR_RST;
			gap_q   <= GAP_TICKS_RST;
		end else if (wr_en) begin
			case (sel)
				REG_FIRST_ADDR: first_q <= pwdata[ADDR_W-1:0];
				REG_LAST_ADDR:  last_q  <= pwdata[ADDR_W-1:0];
				REG_GAP_TICKS:  gap_q   <= pwdata[GAP_TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (sel)
			REG_FIRST_ADDR: prdata = 32'(first_q);
			REG_LAST_ADDR:  prdata = 32'(last_q);
			REG_GAP_TICKS:  prdata = 32'(gap_q);
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg.first_address = first_q;
	assign cfg.last_address  = last_q;
	assign cfg.gap_ticks     = gap_q;

endmodule

// ===== sv/i2cs_seq.sv =====
// I2C address scanner bus phase sequencer: at most one phase per tick.
// Depends on i2cs_pkg for phase codes, cfg_t and res_t.
`timescale 1ns / 1ps
module i2cs_seq
	import i2cs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic start_scan,
	input  logic sda_in,
	input  cfg_t cfg,
	output res_t res
);

	logic [PHASE_W-1:0]          phase_q, phase_d;
	logic [2:0]                  bit_q, bit_d;
	logic [ADDR_W-1:0]           addr_q, addr_d;
	logic [GAP_COUNTER_BITS-1:0] gap_q, gap_d;
	logic [COUNT_W-1:0]          total_q, total_d;
	logic                        scl_q, scl_d;
	logic                        sda_q, sda_d;
	logic                        rel_q, rel_d;
	logic                        ack_v;
	logic                        done;
	logic [2:0]                  bit_sel;

	// Address bit for the current shift position (write bit is 0)
	assign bit_sel = bit_q - 3'd1;

	// Next phase and line levels
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		addr_d  = addr_q;
		gap_d   = gap_q;
		total_d = total_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		rel_d   = rel_q;
		ack_v   = 1'b0;
		done    = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_scan) begin
					total_d = '0;
					addr_d  = cfg.first_address;
					if (cfg.first_address > cfg.last_address) begin
						done = 1'b1;
					end else begin
						sda_d   = 1'b1;
						rel_d   = 1'b0;
						phase_d = PH_S_SCLH;
					end
				end
			end
			PH_S_SCLH: begin
				scl_d   = 1'b1;
				phase_d = PH_S_SDAL;
			end
			PH_S_SDAL: begin
				sda_d   = 1'b0;
				phase_d = PH_S_SCLL;
			end
			PH_S_SCLL: begin
				scl_d   = 1'b0;
				bit_d   = 3'd7;
				phase_d = PH_B_SET;
			end
			PH_B_SET: begin
				sda_d   = (bit_q == 3'd0) ? 1'b0 : addr_q[bit_sel];
				phase_d = PH_B_SCLH;
			end
			PH_B_SCLH: begin
				scl_d   = 1'b1;
				phase_d = PH_B_SCLL;
			end
			PH_B_SCLL: begin
				scl_d = 1'b0;
				if (bit_q == 3'd0) begin
					phase_d = PH_A_REL;
				end else begin
					bit_d   = bit_q - 3'd1;
					phase_d = PH_B_SET;
				end
			end
			PH_A_REL: begin
				rel_d   = 1'b1;
				phase_d = PH_A_SCLH;
			end
			PH_A_SCLH: begin
				// Sample ACK: line low means the address answered
				scl_d = 1'b1;
				if (!sda_in) begin
					ack_v   = 1'b1;
					total_d = total_q + 8'd1;
				end
				phase_d = PH_A_SCLL;
			end
			PH_A_SCLL: begin
				scl_d   = 1'b0;
				phase_d = PH_A_TAKE;
			end
			PH_A_TAKE: begin
				rel_d   = 1'b0;
				phase_d = PH_P_SDAL;
			end
			PH_P_SDAL: begin
				sda_d   = 1'b0;
				phase_d = PH_P_SCLH;
			end
			PH_P_SCLH: begin
				scl_d   = 1'b1;
				phase_d = PH_P_SDAH;
			end
			PH_P_SDAH: begin
				sda_d   = 1'b1;
				gap_d   = gap_load(cfg.gap_ticks);
				phase_d = PH_GAP;
			end
			PH_GAP: begin
				if (gap_q != '0) begin
					gap_d = gap_q - GAP_COUNTER_BITS'(1);
				end else if (addr_q >= cfg.last_address) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					addr_d  = addr_q + 7'd1;
					sda_d   = 1'b1;
					rel_d   = 1'b0;
					phase_d = PH_S_SCLH;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Sequencer state advances on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 3'd7;
			addr_q  <= '0;
			gap_q   <= '0;
			total_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rel_q   <= 1'b0;
		end else if (tick) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			addr_q  <= addr_d;
			gap_q   <= gap_d;
			total_q <= total_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			rel_q   <= rel_d;
		end
	end

	// Result of this tick, taken from the next-state values
	assign res.scl_out      = scl_d;
	assign res.sda_out      = sda_d;
	assign res.sda_released = rel_d;
	assign res.ack_valid    = ack_v;
	assign res.ack_address  = ack_v ? addr_q : '0;
	assign res.busy_res     = (phase_d != PH_IDLE);
	assign res.scan_done    = done;
	assign res.found_count  = total_d;

endmodule

// ===== sv/i2c_address_scanner.sv =====
// Top level of the I2C address scanner: APB registers, phase sequencer and
// output register. Depends on i2cs_pkg, i2cs_apb and i2cs_seq.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    start_scan, sda_in
// output    out        out_valid / out_stall  scl_out .. found_count
// config    in         APB psel/penable       paddr, pwdata, prdata
//
// One tick is taken per clock cycle unless stalled; its result shows in
// the output register on the next cycle. The sequencer's phase step is the
// only logic between the state registers and the output register.
// in_stall rises only while a result sits stalled in the output register.
// Reset puts sequencer lines high, the scan idle, APB registers at defaults.
`timescale 1ns / 1ps
module i2c_address_scanner
	import i2cs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_scan,
	input  logic               sda_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               scl_out,
	output logic               sda_out,
	output logic               sda_released,
	output logic               ack_valid,
	output logic [ADDR_W-1:0]  ack_address,
	output logic               busy_res,
	output logic               scan_done,
	output logic [COUNT_W-1:0] found_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic tick;

	i2cs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept when the output register is empty or being drained
	assign in_stall = out_valid_q && out_stall;
	assign tick     = in_valid && !in_stall;

	i2cs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.start_scan (start_scan),
		.sda_in     (sda_in),
		.cfg        (cfg),
		.res        (res)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (tick) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign scl_out      = res_q.scl_out;
	assign sda_out      = res_q.sda_out;
	assign sda_released = res_q.sda_released;
	assign ack_valid    = res_q.ack_valid;
	assign ack_address  = res_q.ack_address;
	assign busy_res     = res_q.busy_res;
	assign scan_done    = res_q.scan_done;
	assign found_count  = res_q.found_count;

endmodule

// ===== sv/i2cs_chk.sv =====
// Port-level checker for the I2C address scanner, bound to the top level.
// Depends on i2cs_pkg for field widths.
`timescale 1ns / 1ps
module i2cs_chk
	import i2cs_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               scl_out,
	input logic               sda_released,
	input logic               ack_valid,
	input logic               busy_res,
	input logic               scan_done,
	input logic [COUNT_W-1:0] found_count
);

	// Input side stalls only behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// ACK is only sampled with SDA released, SCL high and a nonzero found count
	a_ack_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ack_valid) |-> (sda_released && scl_out && found_count != '0))
		else $error("ack outside the acknowledge clock");

	// The finishing tick is no longer busy and reports no ACK
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && scan_done) |-> (!busy_res && !ack_valid))
		else $error("scan_done while busy or with ack");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(found_count)
			&& $stable(scan_done) && $stable(busy_res)))
		else $error("stalled result changed");

endmodule

bind i2c_address_scanner i2cs_chk u_i2cs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.scl_out      (scl_out),
	.sda_released (sda_released),
	.ack_valid    (ack_valid),
	.busy_res     (busy_res),
	.scan_done    (scan_done),
	.found_count  (found_count)
);

// ===== tb/sv/i2c_address_scanner_test.sv =====
// Self-checking test of the I2C address scanner: APB setup, random and directed
// bus ticks, and an in-bench model of the phase sequencer. Depends on i2cs_pkg.
`timescale 1ns / 1ps
module i2c_address_scanner_test;
	import i2cs_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned RANDOM_TICKS = 1550;
	localparam int unsigned REPORT_MAX   = 10;
	localparam longint     GAP_MAX       = (64'd1 << GAP_COUNTER_BITS) - 1;

	// Choices for the SDA level fed on every tick of a scan
	localparam int SDA_RANDOM = 0;
	localparam int SDA_LOW    = 1;
	localparam int SDA_HIGH   = 2;

	typedef struct packed {
		logic start;
		logic sda;
	} tick_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               start_scan;
	logic               sda_in;
	logic               out_valid;
	logic               out_stall;
	logic               scl_out;
	logic               sda_out;
	logic               sda_released;
	logic               ack_valid;
	logic [ADDR_W-1:0]  ack_address;
	logic               busy_res;
	logic               scan_done;
	logic [COUNT_W-1:0] found_count;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	i2c_address_scanner u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_scan   (start_scan),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_out      (scl_out),
		.sda_out      (sda_out),
		.sda_released (sda_released),
		.ack_valid    (ack_valid),
		.ack_address  (ack_address),
		.busy_res     (busy_res),
		.scan_done    (scan_done),
		.found_count  (found_count),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Stimulus and expectation stores
	tick_t       pending_ticks[$];
	res_t        scan_status_due[$];
	int unsigned ticks_queued;
	int unsigned ticks_taken;
	int unsigned results_seen;
	int unsigned fail_count;
	int unsigned cycle_count;

	// Idle burst odds (1 in N per transaction, 0 = none) and burst counters
	int unsigned in_idle_odds;
	int unsigned out_idle_odds;
	int unsigned in_gap_left;
	int unsigned out_gap_left;

	// Model of the sequencer: configuration and state
	logic [ADDR_W-1:0]           cfg_first;
	logic [ADDR_W-1:0]           cfg_last;
	logic [GAP_TICKS_W-1:0]      cfg_gap;
	logic [PHASE_W-1:0]          bus_phase;
	logic [2:0]                  bit_pos;
	logic [ADDR_W-1:0]           probe_addr;
	logic [GAP_COUNTER_BITS-1:0] gap_left;
	logic [COUNT_W-1:0]          acks_seen;
	logic                        scl_lvl;
	logic                        sda_lvl;
	logic                        sda_rel;

	function automatic void open_address();
		sda_lvl   = 1'b1;
		sda_rel   = 1'b0;
		bus_phase = PH_S_SCLH;
	endfunction

	// One bus phase tick: advance the model, return the line and scan status
	function automatic res_t advance_bus_phase(input logic start, input logic sda);
		res_t r;
		r = '0;
		case (bus_phase)
			PH_IDLE: begin
				if (start) begin
					acks_seen  = '0;
					probe_addr = cfg_first;
					if (cfg_first > cfg_last)
						r.scan_done = 1'b1;
					else
						open_address();
				end
			end
			PH_S_SCLH: begin
				scl_lvl   = 1'b1;
				bus_phase = PH_S_SDAL;
			end
			PH_S_SDAL: begin
				sda_lvl   = 1'b0;
				bus_phase = PH_S_SCLL;
			end
			PH_S_SCLL: begin
				scl_lvl   = 1'b0;
				bit_pos   = 3'd7;
				bus_phase = PH_B_SET;
			end
			PH_B_SET: begin
				// byte is address*2, so bit n carries address bit n-1 and bit 0 is write
				sda_lvl   = (bit_pos == 3'd0) ? 1'b0 : probe_addr[bit_pos - 3'd1];
				bus_phase = PH_B_SCLH;
			end
			PH_B_SCLH: begin
				scl_lvl   = 1'b1;
				bus_phase = PH_B_SCLL;
			end
			PH_B_SCLL: begin
				scl_lvl = 1'b0;
				if (bit_pos == 3'd0)
					bus_phase = PH_A_REL;
				else begin
					bit_pos   = bit_pos - 3'd1;
					bus_phase = PH_B_SET;
				end
			end
			PH_A_REL: begin
				sda_rel   = 1'b1;
				bus_phase = PH_A_SCLH;
			end
			PH_A_SCLH: begin
				scl_lvl = 1'b1;
				if (!sda) begin
					r.ack_valid   = 1'b1;
					r.ack_address = probe_addr;
					acks_seen     = acks_seen + COUNT_W'(1);
				end
				bus_phase = PH_A_SCLL;
			end
			PH_A_SCLL: begin
				scl_lvl   = 1'b0;
				bus_phase = PH_A_TAKE;
			end
			PH_A_TAKE: begin
				sda_rel   = 1'b0;
				bus_phase = PH_P_SDAL;
			end
			PH_P_SDAL: begin
				sda_lvl   = 1'b0;
				bus_phase = PH_P_SCLH;
			end
			PH_P_SCLH: begin
				scl_lvl   = 1'b1;
				bus_phase = PH_P_SDAH;
			end
			PH_P_SDAH: begin
				sda_lvl   = 1'b1;
				gap_left  = (longint'(cfg_gap) > GAP_MAX) ? GAP_COUNTER_BITS'(GAP_MAX)
				                                          : GAP_COUNTER_BITS'(cfg_gap);
				bus_phase = PH_GAP;
			end
			PH_GAP: begin
				if (gap_left != '0)
					gap_left = gap_left - GAP_COUNTER_BITS'(1);
				else if (probe_addr >= cfg_last) begin
					r.scan_done = 1'b1;
					bus_phase   = PH_IDLE;
				end else begin
					probe_addr = probe_addr + ADDR_W'(1);
					open_address();
				end
			end
			default: begin
				bus_phase = PH_IDLE;
			end
		endcase
		r.scl_out      = scl_lvl;
		r.sda_out      = sda_lvl;
		r.sda_released = sda_rel;
		r.busy_res     = (bus_phase != PH_IDLE);
		r.found_count  = acks_seen;
		return r;
	endfunction

	function automatic string show_status(input res_t r);
		return $sformatf("scl=%0b sda=%0b rel=%0b ack=%0b addr=%0d busy=%0b done=%0b found=%0d",
			r.scl_out, r.sda_out, r.sda_released, r.ack_valid, r.ack_address,
			r.busy_res, r.scan_done, r.found_count);
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** i2c_address_scanner: FAILED **");
			$finish;
		end
	end

	// Input driver: pops ticks, holds them while stalled, idles in bursts
	always @(posedge clk) begin
		tick_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap_left != 0) begin
				in_valid    <= 1'b0;
				in_gap_left <= in_gap_left - 1;
			end else if (pending_ticks.size() == 0) begin
				in_valid <= 1'b0;
			end else if (in_idle_odds != 0 && $urandom_range(0, in_idle_odds - 1) == 0) begin
				in_valid    <= 1'b0;
				in_gap_left <= $urandom_range(0, 15);
			end else begin
				nxt = pending_ticks.pop_front();
				in_valid   <= 1'b1;
				start_scan <= nxt.start;
				sda_in     <= nxt.sda;
			end
		end
	end

	// Output receiver: stalls in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_gap_left != 0) begin
			out_stall    <= 1'b1;
			out_gap_left <= out_gap_left - 1;
		end else if (out_idle_odds != 0 && $urandom_range(0, out_idle_odds - 1) == 0) begin
			out_stall    <= 1'b1;
			out_gap_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: check each result transaction, predict each input transaction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{scl_out, sda_out, sda_released, ack_valid, ack_address,
				        busy_res, scan_done, found_count};
				if (scan_status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("result %0d with nothing expected: %s",
							results_seen, show_status(got));
				end else begin
					want = scan_status_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("result %0d mismatch\n  expected %s\n  actual   %s",
								results_seen, show_status(want), show_status(got));
					end
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				scan_status_due.push_back(advance_bus_phase(start_scan, sda_in));
				ticks_taken++;
			end
		end
	end

	task automatic push_tick(input logic start, input logic sda);
		pending_ticks.push_back('{start, sda});
		ticks_queued++;
	endtask

	// Wait until every queued tick is taken and every result checked
	task automatic drain();
		while (ticks_taken != ticks_queued || scan_status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, register written on the ready edge
	task automatic write_reg(input logic [REG_SEL_W-1:0] sel, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({sel, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (sel)
			REG_FIRST_ADDR: cfg_first = value[ADDR_W-1:0];
			REG_LAST_ADDR:  cfg_last  = value[ADDR_W-1:0];
			REG_GAP_TICKS:  cfg_gap   = value[GAP_TICKS_W-1:0];
			default: ;
		endcase
	endtask

	// Junk in the unused upper bits half of the time
	function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
		logic [31:0] mask;
		mask = (32'd1 << width) - 1;
		if ($urandom_range(0, 1))
			return value;
		return ($urandom & ~mask) | (value & mask);
	endfunction

	// One scan: program the range and gap, start, feed the scan's ticks amid idle ones
	task automatic scan_phase(input int first, input int last, input int gap,
			input int sda_mode);
		int unsigned n_ticks;
		logic        sda;
		write_reg(REG_FIRST_ADDR, with_junk(first, ADDR_W));
		write_reg(REG_LAST_ADDR, with_junk(last, ADDR_W));
		write_reg(REG_GAP_TICKS, with_junk(gap, GAP_TICKS_W));
		repeat ($urandom_range(0, 3))
			push_tick(1'b0, 1'($urandom));
		push_tick(1'b1, 1'($urandom));
		// each address: 3 start, 24 bit, 4 ack, 3 stop and gap+1 idle ticks
		n_ticks = (first > last) ? 0 : (last - first + 1) * (35 + gap);
		repeat (n_ticks) begin
			case (sda_mode)
				SDA_LOW:  sda = 1'b0;
				SDA_HIGH: sda = 1'b1;
				default:  sda = 1'($urandom);
			endcase
			// start requests while busy must be ignored
			push_tick($urandom_range(0, 7) == 0, sda);
		end
		repeat ($urandom_range(1, 3))
			push_tick(1'b0, 1'($urandom));
		drain();
	endtask

	initial begin
		int unsigned random_base;
		int          kind;
		int          first;
		int          last;
		int          gap;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		start_scan    = 1'b0;
		sda_in        = 1'b0;
		out_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		ticks_queued  = 0;
		ticks_taken   = 0;
		results_seen  = 0;
		fail_count    = 0;
		cycle_count   = 0;
		in_idle_odds  = 0;
		out_idle_odds = 0;
		in_gap_left   = 0;
		out_gap_left  = 0;
		cfg_first     = FIRST_ADDR_RST;
		cfg_last      = LAST_ADDR_RST;
		cfg_gap       = GAP_TICKS_RST;
		bus_phase     = PH_IDLE;
		bit_pos       = 3'd7;
		probe_addr    = '0;
		gap_left      = '0;
		acks_seen     = '0;
		scl_lvl       = 1'b1;
		sda_lvl       = 1'b1;
		sda_rel       = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle ticks on reset values, empty range, both address extremes
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		drain();
		scan_phase(127, 0, 0, SDA_RANDOM);
		scan_phase(0, 0, 0, SDA_LOW);
		scan_phase(127, 127, 1, SDA_HIGH);

		// Random scans over short ranges
		random_base = ticks_queued;
		while (ticks_queued - random_base < RANDOM_TICKS) begin
			if (ticks_queued - random_base > RANDOM_TICKS - 250) begin
				in_idle_odds  = 0;
				out_idle_odds = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				in_idle_odds  = 0;
				out_idle_odds = 0;
			end else begin
				in_idle_odds  = $urandom_range(3, 12);
				out_idle_odds = $urandom_range(3, 12);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					first = $urandom_range(1, 127);
					last  = $urandom_range(0, first - 1);
				end
				1: begin
					first = 0;
					last  = $urandom_range(0, 3);
				end
				2: begin
					first = $urandom_range(124, 127);
					last  = 127;
				end
				default: begin
					first = $urandom_range(0, 127);
					last  = first + $urandom_range(0, 3);
					if (last > 127)
						last = 127;
				end
			endcase
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
			scan_phase(first, last, gap, SDA_RANDOM);
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** i2c_address_scanner: PASSED **");
		else
			$display("** i2c_address_scanner: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/i2cs_pkg.sv
sv/i2cs_apb.sv
sv/i2cs_seq.sv
sv/i2c_address_scanner.sv
sv/i2cs_chk.sv
tb/sv/i2c_address_scanner_test.sv
